[hdl/mps_pkg.sv]
// Shared types, codes and defaults for the multilevel process scheduler.
package mps_pkg;

   localparam int NUM_PROCS_DEFAULT = 16;
   localparam int IDX_W = 4;
   localparam int CFG_DATA_W = 16;
   localparam int CFG_ADDR_W = 1;

   localparam logic [CFG_ADDR_W-1:0] CSR_NICE_NEUTRAL = 1'd0;
   localparam logic [CFG_ADDR_W-1:0] CSR_QUANTUM = 1'd1;

   localparam logic [5:0] NICE_NEUTRAL_RESET = 6'd20;
   localparam logic [15:0] QUANTUM_RESET = 16'd50;
   localparam logic [5:0] NICE_RESET = 6'd20;

   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_READY = 3'd1;
   localparam logic [2:0] OP_RESUME = 3'd2;
   localparam logic [2:0] OP_STOP = 3'd3;
   localparam logic [2:0] OP_YIELD = 3'd4;

   localparam logic [1:0] ST_READY = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_STOPPED = 2'd2;
   localparam logic [1:0] ST_WAITING = 2'd3;

   localparam logic [1:0] KIND_ALARM = 2'd0;
   localparam logic [1:0] KIND_CHILD = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] index;
      logic entry_valid;
      logic [1:0] entry_state;
      logic [5:0] entry_nice;
      logic [31:0] entry_alarm;
      logic [3:0] entry_parent;
      logic [31:0] tick_now;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] target;
      logic switched;
      logic last;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic do_write;
      logic do_ready;
      logic do_resume;
      logic do_stop;
      logic yield_start;
      logic alarm_step;
      logic sel_step;
      logic fifo_step;
      logic dispatch;
      logic emit_alarm;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
      logic alarm_hit;
   } sts_type;

endpackage

[hdl/mps_datapath.sv]
// Process table, scan pointer and selection registers of the scheduler.
module mps_datapath #(
   parameter int NUM_PROCS = mps_pkg::NUM_PROCS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  mps_pkg::req_type req_ff,
   input  mps_pkg::cmd_type cmd,
   input  logic [5:0] nice_neutral,
   input  logic [15:0] quantum,
   output mps_pkg::sts_type sts,
   output logic [3:0] parent_of_current,
   output logic [3:0] scan_target,
   output logic [3:0] next_target,
   output logic next_switched
);
   import mps_pkg::*;

   localparam int PW = $clog2(NUM_PROCS);
   localparam int CW = $clog2(NUM_PROCS + 1);

   logic [NUM_PROCS-1:0] valid_ff;
   logic [1:0] state_ff [NUM_PROCS];
   logic [5:0] nice_ff [NUM_PROCS];
   logic [15:0] age_ff [NUM_PROCS];
   logic [31:0] alarm_ff [NUM_PROCS];
   logic [3:0] parent_ff [NUM_PROCS];
   logic [PW-1:0] cur_ff;
   logic [CW-1:0] ptr_ff;
   logic [PW-1:0] next_ff;
   logic have_ff;
   logic [PW-1:0] ptr;
   logic in_range;
   logic [PW-1:0] widx;
   logic cand, take, cand_fifo;

   assign ptr = ptr_ff[PW-1:0];
   assign in_range = ({{(32-IDX_W){1'b0}}, req_ff.index} < NUM_PROCS);
   assign widx = PW'(req_ff.index);
   assign sts.scan_done = (ptr_ff == CW'(NUM_PROCS - 1));
   assign sts.alarm_hit = valid_ff[ptr] && (alarm_ff[ptr] != 32'd0)
      && (alarm_ff[ptr] < req_ff.tick_now);
   assign cand = (state_ff[ptr] == ST_READY) && (nice_ff[ptr] < nice_neutral);
   assign take = !have_ff || (nice_ff[ptr] < nice_ff[next_ff])
      || ((nice_ff[ptr] == nice_ff[next_ff]) && (age_ff[ptr] > age_ff[next_ff]));
   assign cand_fifo = (state_ff[ptr] == ST_READY) && (nice_ff[ptr] >= nice_neutral);
   assign parent_of_current = parent_ff[cur_ff];
   assign scan_target = 4'(ptr);
   assign next_target = 4'(next_ff);
   assign next_switched = (next_ff != cur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_PROCS; i++) begin
            state_ff[i] <= ST_WAITING;
            nice_ff[i] <= NICE_RESET;
            age_ff[i] <= '0;
            alarm_ff[i] <= '0;
            parent_ff[i] <= '0;
         end
         cur_ff <= '0;
         ptr_ff <= '0;
         next_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         if (cmd.do_write && in_range) begin
            valid_ff[widx] <= req_ff.entry_valid;
            state_ff[widx] <= req_ff.entry_state;
            nice_ff[widx] <= req_ff.entry_nice;
            alarm_ff[widx] <= req_ff.entry_alarm;
            parent_ff[widx] <= req_ff.entry_parent;
            age_ff[widx] <= '0;
         end
         if (cmd.do_ready && in_range) begin
            state_ff[widx] <= ST_READY;
            age_ff[widx] <= '0;
         end
         if (cmd.do_resume && in_range && state_ff[widx] == ST_STOPPED) begin
            state_ff[widx] <= ST_READY;
            age_ff[widx] <= '0;
         end
         if (cmd.do_stop) begin
            state_ff[cur_ff] <= ST_STOPPED;
         end
         if (cmd.yield_start) begin
            if (state_ff[cur_ff] == ST_RUNNING) begin
               state_ff[cur_ff] <= ST_READY;
               age_ff[cur_ff] <= '0;
            end
            ptr_ff <= CW'(1);
            next_ff <= '0;
            have_ff <= 1'b0;
         end
         if (cmd.alarm_step) begin
            if (sts.alarm_hit) begin
               alarm_ff[ptr] <= '0;
            end
            ptr_ff <= sts.scan_done ? CW'(1) : ptr_ff + CW'(1);
         end
         if (cmd.sel_step) begin
            if (cand) begin
               if (take) begin
                  next_ff <= ptr;
                  have_ff <= 1'b1;
               end else if (age_ff[ptr] != 16'hFFFF) begin
                  age_ff[ptr] <= age_ff[ptr] + 16'd1;
               end
            end
            ptr_ff <= sts.scan_done ? CW'(1) : ptr_ff + CW'(1);
         end
         if (cmd.fifo_step) begin
            if (!have_ff && cand_fifo) begin
               next_ff <= ptr;
               have_ff <= 1'b1;
            end
            ptr_ff <= ptr_ff + CW'(1);
         end
         if (cmd.dispatch) begin
            state_ff[next_ff] <= ST_RUNNING;
            age_ff[next_ff] <= quantum;
            cur_ff <= next_ff;
         end
      end
   end

   // A dispatched process is always left running.
   assert property (@(posedge clock) disable iff (reset)
      cmd.dispatch |=> state_ff[cur_ff] == ST_RUNNING)
      else $error("dispatched process not running");
   // The scan pointer never points at the idle entry during a scan step.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.alarm_step || cmd.sel_step || cmd.fifo_step) |-> ptr_ff != '0)
      else $error("scan touched idle entry");
   // An alarm that fires during a scan step is cleared after its signal.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.alarm_step && sts.alarm_hit) |=> alarm_ff[$past(ptr)] == 32'd0)
      else $error("alarm not cleared");

endmodule

[hdl/mps_control.sv]
// Sequencer for events and the yield scans of the scheduler.
module mps_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  mps_pkg::req_type req_in,
   output mps_pkg::req_type req_ff,
   output logic rsp_valid,
   input  logic rsp_stall,
   output mps_pkg::rsp_type rsp,
   output mps_pkg::cmd_type cmd,
   input  mps_pkg::sts_type sts,
   input  logic [3:0] parent_of_current,
   input  logic [3:0] scan_target,
   input  logic [3:0] next_target,
   input  logic next_switched
);
   import mps_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_YSTART, S_ALARM, S_SEL, S_FIFO, S_DISP, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic out_valid_ff;
   rsp_type out_ff;
   state_type ret_ff;
   logic have_fifo;

   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign have_fifo = 1'b0;

   // Commands decode from the current state.
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (req_ff.op)
               OP_WRITE: begin cmd.do_write = 1'b1; state_in = S_IDLE; end
               OP_READY: begin cmd.do_ready = 1'b1; state_in = S_IDLE; end
               OP_RESUME: begin cmd.do_resume = 1'b1; state_in = S_IDLE; end
               OP_STOP: begin
                  if (!out_valid_ff) begin
                     cmd.do_stop = 1'b1;
                     state_in = S_YSTART;
                  end
               end
               OP_YIELD: state_in = S_YSTART;
               default: state_in = S_IDLE;
            endcase
         end
         S_YSTART: begin
            cmd.yield_start = 1'b1;
            state_in = S_ALARM;
         end
         S_ALARM: begin
            if (!(sts.alarm_hit && out_valid_ff)) begin
               cmd.alarm_step = 1'b1;
               cmd.emit_alarm = sts.alarm_hit;
               if (sts.scan_done) state_in = S_SEL;
            end
         end
         S_SEL: begin
            cmd.sel_step = 1'b1;
            if (sts.scan_done) state_in = S_FIFO;
         end
         S_FIFO: begin
            cmd.fifo_step = 1'b1;
            if (sts.scan_done) state_in = S_DISP;
         end
         S_DISP: begin
            if (!out_valid_ff) begin
               cmd.dispatch = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         ret_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff <= state_ff;
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (state_ff == S_IDLE && req_valid) req_ff <= req_in;
         if (cmd.do_stop) begin
            out_valid_ff <= 1'b1;
            out_ff <= '{kind: KIND_CHILD, target: parent_of_current,
                        switched: 1'b0, last: 1'b0};
         end
         if (cmd.emit_alarm) begin
            out_valid_ff <= 1'b1;
            out_ff <= '{kind: KIND_ALARM, target: scan_target,
                        switched: 1'b0, last: 1'b0};
         end
         if (cmd.dispatch) begin
            out_valid_ff <= 1'b1;
            out_ff <= '{kind: KIND_DISPATCH, target: next_target,
                        switched: next_switched, last: 1'b1};
         end
      end
   end

   // A result may be produced only while the output register is empty.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_alarm || cmd.dispatch || cmd.do_stop) |-> !out_valid_ff)
      else $error("result overwrote pending output");
   // A dispatch always returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.dispatch |=> state_ff == S_IDLE)
      else $error("dispatch did not end event");
   // The fifo flag and return tracking stay consistent.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_YSTART |-> !have_fifo && ret_ff == S_EXEC)
      else $error("yield entered from wrong state");

endmodule

[hdl/multilevel_process_scheduler.sv]
// Top level of the multilevel process scheduler.
// Write, make ready and resume requests and unused ops end without a scan.
// A yield or stop is paced by three passes of one scan pointer, plus stalls on results.
// One request is worked on at a time; results leave through one output register.
// Synchronous active-high reset clears the table to waiting entries and the
// registers to nice_neutral 20 and quantum 50.
module multilevel_process_scheduler #(
   parameter int NUM_PROCS = mps_pkg::NUM_PROCS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  mps_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output mps_pkg::rsp_type rsp_data,
   input  logic csr_write,
   input  logic [mps_pkg::CFG_ADDR_W-1:0] csr_index,
   input  logic [mps_pkg::CFG_DATA_W-1:0] csr_data
);
   import mps_pkg::*;

   logic [5:0] nice_neutral_ff;
   logic [15:0] quantum_ff;
   req_type req_ff;
   cmd_type cmd;
   sts_type sts;
   logic [3:0] parent_of_current, scan_target, next_target;
   logic next_switched;

   // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         nice_neutral_ff <= NICE_NEUTRAL_RESET;
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NICE_NEUTRAL: nice_neutral_ff <= csr_data[5:0];
            CSR_QUANTUM: quantum_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mps_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_in(req_data), .req_ff,
      .rsp_valid, .rsp_stall, .rsp(rsp_data), .cmd, .sts,
      .parent_of_current, .scan_target, .next_target, .next_switched
   );

   mps_datapath #(.NUM_PROCS(NUM_PROCS)) u_datapath (
      .clock, .reset, .req_ff, .cmd, .nice_neutral(nice_neutral_ff),
      .quantum(quantum_ff), .sts, .parent_of_current, .scan_target,
      .next_target, .next_switched
   );

endmodule

[tb/multilevel_process_scheduler_tb.sv]
// Self-checking testbench for the multilevel process scheduler.
`timescale 1ns / 1ps

module multilevel_process_scheduler_tb;
   import mps_pkg::*;

   localparam int NP = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   // Scoreboard: keeps its own copy of the process table, predicts the
   // results of each accepted request and checks returned results in order.
   class sched_scoreboard;
      logic       vbit [NP];
      logic [1:0] rstate [NP];
      logic [5:0] nice [NP];
      logic [15:0] age [NP];
      logic [31:0] alarm [NP];
      logic [3:0] parent [NP];
      logic [3:0] cur;
      logic [5:0] neutral;
      logic [15:0] quantum;
      rsp_type    pending [$];
      int         errors;
      int         checked;

      function void clear();
         for (int i = 0; i < NP; i++) begin
            vbit[i] = 0; rstate[i] = ST_WAITING; nice[i] = NICE_RESET;
            age[i] = 0; alarm[i] = 0; parent[i] = 0;
         end
         cur = 0; neutral = NICE_NEUTRAL_RESET; quantum = QUANTUM_RESET;
         pending.delete(); errors = 0; checked = 0;
      endfunction

      function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
         if (idx == CSR_NICE_NEUTRAL) neutral = val[5:0];
         else quantum = val;
      endfunction

      function void push(logic [1:0] k, logic [3:0] t, logic s, logic l);
         rsp_type r;
         r.kind = k; r.target = t; r.switched = s; r.last = l;
         pending.push_back(r);
      endfunction

      function void yield_cpu(logic [31:0] now);
         int nxt;
         bit have;
         nxt = 0; have = 0;
         if (rstate[cur] == ST_RUNNING) begin
            rstate[cur] = ST_READY; age[cur] = 0;
         end
         for (int i = 1; i < NP; i++)
            if (vbit[i] && alarm[i] != 0 && alarm[i] < now) begin
               alarm[i] = 0;
               push(KIND_ALARM, i[3:0], 0, 0);
            end
         // Priority class: lowest nice, then highest age; losers age.
         for (int i = 1; i < NP; i++) begin
            if (rstate[i] != ST_READY || nice[i] >= neutral) continue;
            if (!have || nice[i] < nice[nxt] ||
                (nice[i] == nice[nxt] && age[i] > age[nxt])) begin
               nxt = i; have = 1;
            end else if (age[i] != 16'hFFFF) begin
               age[i]++;
            end
         end
         if (!have)
            for (int i = 1; i < NP; i++)
               if (rstate[i] == ST_READY && nice[i] >= neutral) begin
                  nxt = i; break;
               end
         rstate[nxt] = ST_RUNNING;
         age[nxt] = quantum;
         push(KIND_DISPATCH, nxt[3:0], nxt[3:0] != cur, 1);
         cur = nxt[3:0];
      endfunction

      function void note_request(req_type q);
         case (q.op)
            OP_WRITE: begin
               vbit[q.index] = q.entry_valid; rstate[q.index] = q.entry_state;
               nice[q.index] = q.entry_nice; alarm[q.index] = q.entry_alarm;
               parent[q.index] = q.entry_parent; age[q.index] = 0;
            end
            OP_READY: begin
               rstate[q.index] = ST_READY; age[q.index] = 0;
            end
            OP_RESUME: if (rstate[q.index] == ST_STOPPED) begin
               rstate[q.index] = ST_READY; age[q.index] = 0;
            end
            OP_STOP: begin
               rstate[cur] = ST_STOPPED;
               push(KIND_CHILD, parent[cur], 0, 0);
               yield_cpu(q.tick_now);
            end
            OP_YIELD: yield_cpu(q.tick_now);
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result kind=%0d target=%0d", $time,
                     got.kind, got.target);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         checked++;
         if (got.kind != exp_r.kind)
            $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
         if (got.target != exp_r.target)
            $display("%0t: target expected %0d actual %0d", $time,
                     exp_r.target, got.target);
         if (got.switched != exp_r.switched)
            $display("%0t: switched expected %0d actual %0d", $time,
                     exp_r.switched, got.switched);
         if (got.last != exp_r.last)
            $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
         if (got != exp_r) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_write = 0;
   logic [CFG_ADDR_W-1:0] csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data = '0;

   sched_scoreboard sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 0;
   int  accepted_reqs = 0;
   int  quiet_cycles = 0;
   int  yields_sent = 0;

   always #5 clock = ~clock;

   multilevel_process_scheduler #(.NUM_PROCS(NP)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // The receiver stalls at random, or for a whole stretch when held off.
   always @(posedge clock) begin
      if (recv_hold) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Results are checked on the edge that accepts them; the sampled values
   // are those present before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Watchdog: counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", sb.pending.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one request and hold it until it is accepted. The valid stays high
   // across back-to-back requests so it never sees two assignments per step.
   task automatic send_request(req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(q);
      accepted_reqs++;
      if (q.op == OP_YIELD || q.op == OP_STOP) yields_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      // A write or ready request may still be in flight after the last result.
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.set_reg(idx, val);
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [3:0] idx);
      req_type q;
      q = '0;
      q.op = op; q.index = idx;
      q.entry_valid = 1'($urandom_range(1));
      q.entry_state = 2'($urandom_range(3));
      q.entry_nice = 6'($urandom_range(39));
      // Alarms are mostly small so they expire against small tick values.
      q.entry_alarm = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
      q.entry_parent = 4'($urandom_range(15));
      q.tick_now = ($urandom_range(7) == 0) ? $urandom : $urandom_range(400);
      return q;
   endfunction

   // Random request: mostly a well-formed mix of table edits and yields,
   // with a small share of unused op codes.
   function automatic req_type rand_req();
      int r;
      logic [2:0] op;
      r = $urandom_range(99);
      if (r < 30) op = OP_WRITE;
      else if (r < 50) op = OP_READY;
      else if (r < 58) op = OP_RESUME;
      else if (r < 70) op = OP_STOP;
      else if (r < 96) op = OP_YIELD;
      else op = 3'($urandom_range(7, 5));
      return make_req(op, 4'($urandom_range(15)));
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_request(rand_req());
   endtask

   initial begin
      req_type q;
      sb = new();
      sb.clear();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: yield and stop on an empty table, idle stop, field
      // extremes, both classes, tie on nice, alarms at edge values.
      send_request(make_req(OP_YIELD, 0));
      send_request(make_req(OP_STOP, 0));
      q = make_req(OP_WRITE, 15);
      q.entry_valid = 1; q.entry_state = ST_READY; q.entry_nice = 39;
      q.entry_alarm = 32'hFFFFFFFF; q.entry_parent = 15;
      send_request(q);
      q = make_req(OP_WRITE, 1);
      q.entry_valid = 1; q.entry_state = ST_READY; q.entry_nice = 0;
      q.entry_alarm = 5; q.entry_parent = 0;
      send_request(q);
      q = make_req(OP_WRITE, 2);
      q.entry_valid = 1; q.entry_state = ST_STOPPED; q.entry_nice = 0;
      q.entry_alarm = 0; q.entry_parent = 1;
      send_request(q);
      send_request(make_req(OP_RESUME, 2));
      send_request(make_req(OP_RESUME, 3));
      q = make_req(OP_YIELD, 0); q.tick_now = 5;
      send_request(q);
      q = make_req(OP_YIELD, 0); q.tick_now = 6;
      send_request(q);
      send_request(make_req(OP_STOP, 0));
      q = make_req(OP_YIELD, 0); q.tick_now = 32'hFFFFFFFF;
      send_request(q);
      send_request(make_req(OP_READY, 0));
      send_request(make_req(3'd5, 0));
      send_request(make_req(3'd7, 9));
      q = make_req(OP_WRITE, 1); q.entry_state = ST_WAITING; q.entry_nice = 20;
      send_request(q);
      send_request(make_req(OP_YIELD, 0));
      send_request(make_req(OP_STOP, 0));
      go_idle();

      // Phase one: sender idles sometimes, receiver often.
      send_idle_pct = 33; recv_idle_pct = 75;
      write_reg(CSR_NICE_NEUTRAL, 0);
      write_reg(CSR_QUANTUM, 16'hFFFF);
      run_random(100);
      go_idle();

      // Long receiver hold-off while requests keep coming.
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(CSR_NICE_NEUTRAL, 39);
      write_reg(CSR_QUANTUM, 0);
      fork
         begin
            recv_hold = 1;
            repeat (400) @(posedge clock);
            recv_hold = 0;
         end
         for (int i = 0; i < 15; i++) send_request(make_req(OP_YIELD, 0));
      join
      go_idle();

      // Phase two: the other way round.
      send_idle_pct = 75; recv_idle_pct = 33;
      write_reg(CSR_NICE_NEUTRAL, 63);
      write_reg(CSR_QUANTUM, 16'hFFFE);
      run_random(120);
      go_idle();

      // Phase three: no idling, reset-like settings.
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(CSR_NICE_NEUTRAL, 20);
      write_reg(CSR_QUANTUM, 50);
      run_random(140);
      go_idle();

      $display("Run covered %0d requests, %0d yields or stops, %0d results checked,",
               accepted_reqs, yields_sent, sb.checked);
      $display("under three idling mixes, a long output hold-off and five settings.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
